// ----- rtl/pf_pkg.sv -----
// Shared types, constants and letter helpers for the Playfair digram encryptor.
`default_nettype none
package pf_pkg;

    localparam int LETTER_COUNT = 26;
    localparam int CELLS        = 25;
    localparam int SIDE         = 5;
    localparam int LW           = 5;

    localparam logic [LW-1:0] LETTER_I = 5'd8;
    localparam logic [LW-1:0] LETTER_J = 5'd9;
    localparam logic [LW-1:0] LETTER_Z = 5'd25;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_KEY     = 2'd1,
        CMD_FINISH  = 2'd2,
        CMD_ENCRYPT = 2'd3
    } cmd_t;

    // Write request into one of the two stores.
    typedef struct packed {
        logic          en;
        logic [LW-1:0] addr;
        logic [LW-1:0] data;
    } mem_wr_t;

    // Clamp codes above z to z, then fold j onto i.
    function automatic logic [LW-1:0] fold_letter(input logic [LW-1:0] raw);
        logic [LW-1:0] v;
        v = (raw > LETTER_Z) ? LETTER_Z : raw;
        return (v == LETTER_J) ? LETTER_I : v;
    endfunction

    // Row of a cell index, by compare ladder.
    function automatic logic [2:0] pos_row(input logic [LW-1:0] pos);
        logic [2:0] r;
        if (pos >= 5'(4 * SIDE))      r = 3'd4;
        else if (pos >= 5'(3 * SIDE)) r = 3'd3;
        else if (pos >= 5'(2 * SIDE)) r = 3'd2;
        else if (pos >= 5'(SIDE))     r = 3'd1;
        else                          r = 3'd0;
        return r;
    endfunction

    // Cell index from row and column.
    function automatic logic [LW-1:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        logic [LW-1:0] p;
        p = 5'(r) * 5'(SIDE) + 5'(c);
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pf_place_mem.sv -----
// Letter-to-cell store: one write port, two registered read ports.
`default_nettype none
module pf_place_mem
    import pf_pkg::*;
(
    input  wire logic          aclk,
    input  wire mem_wr_t       wr,
    input  wire logic          rd_en,
    input  wire logic [LW-1:0] rd_addr_a,
    input  wire logic [LW-1:0] rd_addr_b,
    output logic      [LW-1:0] rd_data_a,
    output logic      [LW-1:0] rd_data_b
);

    logic [LW-1:0] mem [LETTER_COUNT];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pf_table_mem.sv -----
// Key table store (cell to letter): one write port, two registered read ports.
`default_nettype none
module pf_table_mem
    import pf_pkg::*;
(
    input  wire logic          aclk,
    input  wire mem_wr_t       wr,
    input  wire logic          rd_en,
    input  wire logic [LW-1:0] rd_addr_a,
    input  wire logic [LW-1:0] rd_addr_b,
    output logic      [LW-1:0] rd_data_a,
    output logic      [LW-1:0] rd_data_b
);

    logic [LW-1:0] mem [CELLS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pf_rule.sv -----
// Playfair row, column and rectangle rule on a pair of cell indexes.
`default_nettype none
module pf_rule
    import pf_pkg::*;
(
    input  wire logic [LW-1:0] pos_a,
    input  wire logic [LW-1:0] pos_b,
    output logic      [LW-1:0] out_a,
    output logic      [LW-1:0] out_b
);

    logic [2:0] ra, rb, ca, cb;

    // Advance one place with wraparound.
    function automatic logic [2:0] step(input logic [2:0] v);
        return (v >= 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    always_comb begin
        ra = pos_row(pos_a);
        rb = pos_row(pos_b);
        ca = 3'(pos_a - 5'(ra) * 5'(SIDE));
        cb = 3'(pos_b - 5'(rb) * 5'(SIDE));
        if (ra == rb) begin
            out_a = cell_of(ra, step(ca));
            out_b = cell_of(rb, step(cb));
        end else if (ca == cb) begin
            out_a = cell_of(step(ra), ca);
            out_b = cell_of(step(rb), cb);
        end else begin
            out_a = cell_of(ra, cb);
            out_b = cell_of(rb, ca);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/playfair_digram_encryptor_core.sv -----
// Top level of the Playfair digram encryptor: control, key building and result register.
//
// Channel  Dir  Handshake         Payload
// s_       in   s_tvalid/tready   s_tuser = command, s_tdata = letter_a, letter_b
// m_       out  m_tvalid/tready   m_tuser = not_ready, m_tdata = cipher_a, cipher_b
//
// Clear and key-letter transactions finish in the cycle they are accepted.
// Finish walks all 26 letters through the stores, one per cycle, busy until the walk ends.
// Encrypt runs as letter-to-cell read, key table read, result load; the two
// registered memory reads are chained. A not-ready encrypt skips the table read.
// A waiting result holds only a following encrypt, in its last step with tready
// low, until the result register is free. Reset is synchronous, active low.
`default_nettype none
module playfair_digram_encryptor_core
    import pf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [4:0] letter_a, [9:5] letter_b, [15:10] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [4:0] cipher_a, [9:5] cipher_b, [15:10] zero
    output logic      [0:0]  m_tuser    // [0] not_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOKUP,
        ST_RESULT
    } state_t;

    state_t                  state_reg, state_next;
    logic [LETTER_COUNT-1:0] used_reg, used_next;
    logic [LW-1:0]           fill_reg, fill_next;
    logic                    ready_reg, ready_next;
    logic [LW-1:0]           walk_reg, walk_next;
    logic                    nr_reg, nr_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [15:0]             m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    logic          accept;
    cmd_t          cmd;
    logic [LW-1:0] letter_a, letter_b;
    logic [LW-1:0] cand;
    logic          cand_used, place_ok, do_place;
    logic          out_free;

    mem_wr_t       place_wr, table_wr;
    logic [LW-1:0] pos_a, pos_b, cell_a, cell_b, key_a, key_b;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign letter_a = s_tdata[4:0];
    assign letter_b = s_tdata[9:5];
    assign out_free = !m_tvalid_reg || m_tready;

    // Candidate letter for the key table: the walk counter while finishing,
    // otherwise the incoming key letter.
    assign cand      = (state_reg == ST_FILL) ? walk_reg : letter_a;
    assign cand_used = (cand < 5'(LETTER_COUNT)) ? used_reg[cand] : 1'b1;
    assign place_ok  = (cand != LETTER_J) && !cand_used && (fill_reg < 5'(CELLS));
    assign do_place  = place_ok &&
                       ((state_reg == ST_FILL) ||
                        (accept && cmd == CMD_KEY && !ready_reg));

    assign table_wr = '{en: do_place, addr: fill_reg, data: cand};
    assign place_wr = '{en: do_place, addr: cand, data: fill_reg};

    // Letter-to-cell lookup, issued at the encrypt accept.
    pf_place_mem u_place (
        .aclk      (aclk),
        .wr        (place_wr),
        .rd_en     (accept && cmd == CMD_ENCRYPT),
        .rd_addr_a (fold_letter(letter_a)),
        .rd_addr_b (fold_letter(letter_b)),
        .rd_data_a (pos_a),
        .rd_data_b (pos_b)
    );

    pf_rule u_rule (
        .pos_a (pos_a),
        .pos_b (pos_b),
        .out_a (cell_a),
        .out_b (cell_b)
    );

    // Key table read of the two target cells.
    pf_table_mem u_table (
        .aclk      (aclk),
        .wr        (table_wr),
        .rd_en     (state_reg == ST_LOOKUP),
        .rd_addr_a (cell_a),
        .rd_addr_b (cell_b),
        .rd_data_a (key_a),
        .rd_data_b (key_b)
    );

    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        fill_next     = fill_reg;
        ready_next    = ready_reg;
        walk_next     = walk_reg;
        nr_next       = nr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // Drop the result once the sink takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (do_place) begin
            used_next[cand] = 1'b1;
            fill_next       = fill_reg + 5'd1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_CLEAR: begin
                            used_next  = '0;
                            fill_next  = '0;
                            ready_next = 1'b0;
                        end
                        CMD_KEY: begin
                        end
                        CMD_FINISH: begin
                            walk_next  = '0;
                            state_next = ST_FILL;
                        end
                        CMD_ENCRYPT: begin
                            nr_next    = !ready_reg;
                            state_next = ready_reg ? ST_LOOKUP : ST_RESULT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                walk_next = walk_reg + 5'd1;
                if (walk_reg == 5'(LETTER_COUNT - 1)) begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // Hold until the result register is free.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = nr_reg;
                    m_tdata_next  = nr_reg ? 16'd0 : {6'd0, key_b, key_a};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            fill_reg     <= '0;
            ready_reg    <= 1'b0;
            walk_reg     <= '0;
            nr_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            fill_reg     <= fill_next;
            ready_reg    <= ready_next;
            walk_reg     <= walk_next;
            nr_reg       <= nr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Fill count tracks the set of placed letters, j is never placed.
    a_fill_matches_used: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(used_reg) == int'(fill_reg)) && !used_reg[LETTER_J])
        else $error("fill count out of step with used letters");

    // A finished table is always full.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> (fill_reg == 5'(CELLS)))
        else $error("table marked ready but not full");

    // A not-ready result carries zero letters.
    a_nr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("not-ready result with nonzero letters");

    // An encrypt with a ready table reaches the table read in the next cycle.
    a_encrypt_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_ENCRYPT && ready_reg) |=> (state_reg == ST_LOOKUP))
        else $error("encrypt did not start its lookup");

endmodule
`default_nettype wire
